FILE: rtl/core/jdm_pkg.sv
// Package of the joystick drive mixer: register indexes, frame constants
// and fixed widths. Depends on nothing; used by jdm_out_if, top level, checker.
`default_nettype none
package jdm_pkg;
    localparam int CFG_W      = 12;   // widest configuration register
    localparam int CFG_IDX_W  = 3;
    localparam int MAG_W      = 7;    // scaled magnitude 0..127
    localparam int FRAME_LEN  = 5;
    localparam int IDX_W      = 3;
    localparam int FULL_SCALE = 127;
    localparam int RECIP_MUL  = 258;  // floor(2^15 / 127), never overshoots
    localparam int RECIP_SH   = 15;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_LOW    = 3'd0;
    localparam t_cfg_idx REG_CENTER = 3'd1;
    localparam t_cfg_idx REG_HIGH   = 3'd2;
    localparam t_cfg_idx REG_DEAD   = 3'd3;
    localparam t_cfg_idx REG_ADDR   = 3'd4;
    localparam t_cfg_idx REG_POWER  = 3'd5;
    localparam t_cfg_idx REG_STOP   = 3'd6;

    typedef logic [IDX_W-1:0] t_byte_idx;
    localparam t_byte_idx BYTE_LAST = 3'd4;

    localparam logic [CFG_W-1:0] RST_LOW    = 12'd0;
    localparam logic [CFG_W-1:0] RST_CENTER = 12'd1961;
    localparam logic [CFG_W-1:0] RST_HIGH   = 12'd3921;
    localparam logic [MAG_W-1:0] RST_DEAD   = 7'd5;
    localparam logic [7:0]       RST_ADDR   = 8'hC5;
    localparam logic [7:0]       RST_POWER  = 8'h25;
    localparam logic [7:0]       RST_STOP   = 8'h26;
endpackage
`default_nettype wire

FILE: rtl/core/jdm_in_if.sv
// Input channel of the joystick drive mixer: one request carries an X/Y sample pair.
// Depends on nothing but its width parameter.
`default_nettype none
interface jdm_in_if #(parameter int SAMPLE_BITS = 12);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] x_sample;
    logic [SAMPLE_BITS-1:0] y_sample;
    modport source (output valid, output x_sample, output y_sample, input ready);
    modport sink   (input valid, input x_sample, input y_sample, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/jdm_out_if.sv
// Output channel of the joystick drive mixer: one request carries one frame byte.
// Depends on jdm_pkg.
`default_nettype none
interface jdm_out_if;
    logic                 valid;
    logic                 ready;
    logic                 motor_select;
    jdm_pkg::t_byte_idx   byte_index;
    logic [7:0]           frame_byte;
    logic                 last_byte;
    modport source (output valid, output motor_select, output byte_index,
                    output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input motor_select, input byte_index,
                    input frame_byte, input last_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/joystick_drive_mixer_framer.sv
// Top level of the joystick drive mixer and motor frame builder.
// Depends on jdm_pkg, jdm_in_if and jdm_out_if.
//
// Each accepted request (one X and one Y ADC sample) yields ten output
// requests: the 5-byte frame of motor A, then that of motor B. An item
// passes through the input hold, setup, divider, clamp, product,
// estimate and correction stages before the output frame register; a new
// item may follow every cycle while the pipeline advances, but the single
// output port drains ten bytes per item. The whole pipeline advances
// together whenever the output frame register is empty or hands over its
// last byte; a waiting frame holds every stage, so nothing is lost or
// repeated. The per-axis scaling runs through a 7-stage restoring divider
// (one quotient bit per stage); the inner-motor division by 127 is a
// reciprocal multiply with one correction step. Write configuration only
// while the block is idle; keep low limit < centre < high limit.
`default_nettype none
module joystick_drive_mixer_framer #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire jdm_pkg::t_cfg_idx             i_cfg_idx,
    input  wire logic [jdm_pkg::CFG_W-1:0]     i_cfg_data,
    jdm_in_if.sink                             i_in,
    jdm_out_if.source                          o_out
);
    // Compare width covers both samples and limits.
    localparam int CW  = (SAMPLE_BITS > jdm_pkg::CFG_W) ? SAMPLE_BITS : jdm_pkg::CFG_W;
    localparam int RW  = CW + jdm_pkg::MAG_W;       // numerator times 127
    localparam int QB  = jdm_pkg::MAG_W;            // quotient bits, one per stage
    localparam int NV  = QB + 6;                    // pipeline stages before framing
    localparam int MW  = jdm_pkg::MAG_W;
    localparam int PW  = 2 * MW;
    localparam int RMW = PW + 9;                    // product times reciprocal

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [CW-1:0] den;
        logic [QB-1:0] q;
        logic          clamp;
        logic          neg;
    } t_div;

    // Configuration registers
    logic [jdm_pkg::CFG_W-1:0] r_lo, r_mid, r_hi;
    logic [MW-1:0]             r_dz;
    logic [7:0]                r_addr, r_power, r_stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo    <= jdm_pkg::RST_LOW;
            r_mid   <= jdm_pkg::RST_CENTER;
            r_hi    <= jdm_pkg::RST_HIGH;
            r_dz    <= jdm_pkg::RST_DEAD;
            r_addr  <= jdm_pkg::RST_ADDR;
            r_power <= jdm_pkg::RST_POWER;
            r_stop  <= jdm_pkg::RST_STOP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                jdm_pkg::REG_LOW:    r_lo    <= i_cfg_data;
                jdm_pkg::REG_CENTER: r_mid   <= i_cfg_data;
                jdm_pkg::REG_HIGH:   r_hi    <= i_cfg_data;
                jdm_pkg::REG_DEAD:   r_dz    <= i_cfg_data[MW-1:0];
                jdm_pkg::REG_ADDR:   r_addr  <= i_cfg_data[7:0];
                jdm_pkg::REG_POWER:  r_power <= i_cfg_data[7:0];
                jdm_pkg::REG_STOP:   r_stop  <= i_cfg_data[7:0];
                default: ;           // drop writes to unknown indexes
            endcase
        end
    end

    // Pick the side of the centre, the clamp and the divider operands.
    function automatic t_div f_setup(logic [CW-1:0] v, logic [CW-1:0] lo,
                                     logic [CW-1:0] mid, logic [CW-1:0] hi);
        t_div          d;
        logic [CW-1:0] num;
        d.neg   = (v < mid);
        d.clamp = d.neg ? (v <= lo) : (v >= hi);
        num     = d.neg ? (mid - v) : (v - mid);
        d.den   = d.neg ? (mid - lo) : (hi - mid);
        d.rem   = (RW'(num) << QB) - RW'(num);
        d.q     = '0;
        return d;
    endfunction

    // One restoring division step for quotient bit b.
    function automatic t_div f_step(t_div d, int b);
        t_div          o;
        logic [RW-1:0] sh;
        o  = d;
        sh = RW'(d.den) << b;
        if (d.rem >= sh) begin
            o.rem  = d.rem - sh;
            o.q[b] = 1'b1;
        end
        return o;
    endfunction

    logic [NV-1:0] r_vld;
    logic          r_ser_v;
    logic          w_en;
    logic          w_out_hs;
    logic          w_done;

    // Advance every stage when the frame register is free or handing over.
    assign w_out_hs   = o_out.valid && o_out.ready;
    assign w_done     = w_out_hs && o_out.last_byte;
    assign w_en       = !r_ser_v || w_done;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NV-2:0], i_in.valid};
        end
    end

    // Stage 0: hold the samples
    logic [CW-1:0] r_x0, r_y0;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x0 <= CW'(i_in.x_sample);
            r_y0 <= CW'(i_in.y_sample);
        end
    end

    // Stages 1..8: setup, then one quotient bit per stage
    t_div r_dx [0:QB];
    t_div r_dy [0:QB];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx[0] <= f_setup(r_x0, CW'(r_lo), CW'(r_mid), CW'(r_hi));
            r_dy[0] <= f_setup(r_y0, CW'(r_lo), CW'(r_mid), CW'(r_hi));
        end
    end
    for (genvar k = 1; k <= QB; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dx[k] <= f_step(r_dx[k-1], QB - k);
                r_dy[k] <= f_step(r_dy[k-1], QB - k);
            end
        end
    end

    // Stage 9: clamp and dead zone, as sign and magnitude
    logic [MW-1:0] r_xm9, r_ym9;
    logic          r_xn9, r_yn9;
    logic [MW-1:0] w_xr, w_yr;
    assign w_xr = r_dx[QB].clamp ? MW'(jdm_pkg::FULL_SCALE) : r_dx[QB].q;
    assign w_yr = r_dy[QB].clamp ? MW'(jdm_pkg::FULL_SCALE) : r_dy[QB].q;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xm9 <= (w_xr <= r_dz) ? '0 : w_xr;
            r_xn9 <= (w_xr <= r_dz) ? 1'b0 : r_dx[QB].neg;
            r_ym9 <= (w_yr <= r_dz) ? '0 : w_yr;
            r_yn9 <= (w_yr <= r_dz) ? 1'b0 : r_dy[QB].neg;
        end
    end

    // Stage 10: |y| * (127 - |x|)
    logic [MW-1:0] r_xm10, r_ym10;
    logic          r_xn10, r_yn10;
    logic [PW-1:0] r_p10;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p10  <= PW'(r_ym9) * PW'(MW'(jdm_pkg::FULL_SCALE) - r_xm9);
            r_xm10 <= r_xm9;
            r_ym10 <= r_ym9;
            r_xn10 <= r_xn9;
            r_yn10 <= r_yn9;
        end
    end

    // Stage 11: quotient estimate by reciprocal, at most one short
    logic [MW-1:0]  r_xm11, r_ym11, r_q11;
    logic           r_xn11, r_yn11;
    logic [PW-1:0]  r_p11;
    logic [RMW-1:0] w_rm;
    assign w_rm = RMW'(r_p10) * RMW'(jdm_pkg::RECIP_MUL);
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q11  <= w_rm[jdm_pkg::RECIP_SH +: MW];
            r_p11  <= r_p10;
            r_xm11 <= r_xm10;
            r_ym11 <= r_ym10;
            r_xn11 <= r_xn10;
            r_yn11 <= r_yn10;
        end
    end

    // Stage 12: correct the estimate
    logic [MW-1:0] r_xm12, r_ym12, r_in12;
    logic          r_xn12, r_yn12;
    logic [PW-1:0] w_rem;
    assign w_rem = r_p11 - PW'(r_q11) * PW'(jdm_pkg::FULL_SCALE);
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in12 <= (w_rem >= PW'(jdm_pkg::FULL_SCALE)) ? r_q11 + MW'(1) : r_q11;
            r_xm12 <= r_xm11;
            r_ym12 <= r_ym11;
            r_xn12 <= r_xn11;
            r_yn12 <= r_yn11;
        end
    end

    // Quadrant mix into the two motor values
    logic [MW-1:0] w_ma, w_mb;
    logic          w_na, w_nb;
    logic          w_in_n;
    assign w_in_n = r_yn12 && (r_in12 != '0);
    always_comb begin
        w_ma = r_ym12;
        w_na = r_yn12;
        w_mb = r_in12;
        w_nb = w_in_n;
        if (r_ym12 == '0) begin
            w_ma = '0;
            w_na = 1'b0;
            w_mb = '0;
            w_nb = 1'b0;
        end else if (r_yn12 == r_xn12) begin
            w_ma = r_ym12;
            w_na = r_yn12;
            w_mb = r_in12;
            w_nb = w_in_n;
        end else begin
            w_ma = r_in12;
            w_na = w_in_n;
            w_mb = r_ym12;
            w_nb = r_yn12;
        end
    end

    function automatic logic [jdm_pkg::FRAME_LEN*8-1:0] f_frame(
        logic [MW-1:0] mag, logic neg, logic [7:0] addr,
        logic [7:0] pwr, logic [7:0] stp);
        logic [7:0] b1, b2, b3, b4;
        b1 = (mag == '0) ? stp : pwr;
        b2 = {7'd0, (mag != '0) && !neg};
        b3 = {1'b0, mag};
        b4 = (addr ^ b1 ^ b2 ^ b3) & 8'h7F;
        return {b4, b3, b2, b1, addr};
    endfunction

    // Output frame register: both frames, byte 0 in the low bits
    logic [jdm_pkg::FRAME_LEN*8-1:0] r_fa, r_fb;
    logic                            r_sel;
    jdm_pkg::t_byte_idx              r_idx;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fa <= f_frame(w_ma, w_na, r_addr, r_power, r_stop);
            r_fb <= f_frame(w_mb, w_nb, r_addr, r_power, r_stop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_v <= 1'b0;
            r_sel   <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_en) begin
                r_ser_v <= r_vld[NV-1];
            end
            if (w_out_hs) begin
                if (r_idx == jdm_pkg::BYTE_LAST) begin
                    r_idx <= '0;
                    r_sel <= !r_sel;
                end else begin
                    r_idx <= r_idx + jdm_pkg::t_byte_idx'(1);
                end
            end
        end
    end

    assign o_out.valid        = r_ser_v;
    assign o_out.motor_select = r_sel;
    assign o_out.byte_index   = r_idx;
    assign o_out.frame_byte   = r_sel ? r_fb[r_idx*8 +: 8] : r_fa[r_idx*8 +: 8];
    assign o_out.last_byte    = r_sel && (r_idx == jdm_pkg::BYTE_LAST);
endmodule
`default_nettype wire

FILE: rtl/core/jdm_checker.sv
// Port checker of the joystick drive mixer, bound to the top level.
// Depends on jdm_pkg.
`default_nettype none
module jdm_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_ready,
    input wire logic               o_out_valid,
    input wire logic               o_out_ready,
    input wire logic               o_out_motor_select,
    input wire jdm_pkg::t_byte_idx o_out_byte_index,
    input wire logic               o_out_last_byte
);
    // Last byte only at the end of the motor B frame.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_last_byte |->
            o_out_motor_select && (o_out_byte_index == jdm_pkg::BYTE_LAST))
        else $error("last byte outside the end of frame B");

    // Bytes advance one at a time within a frame.
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_ready && (o_out_byte_index != jdm_pkg::BYTE_LAST) |=>
            o_out_valid && (o_out_byte_index == $past(o_out_byte_index) + 3'd1) &&
            (o_out_motor_select == $past(o_out_motor_select)))
        else $error("byte index skipped");

    // Frame A is followed straight by frame B.
    a_ab: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_ready && !o_out_motor_select &&
        (o_out_byte_index == jdm_pkg::BYTE_LAST) |=>
            o_out_valid && o_out_motor_select && (o_out_byte_index == 3'd0))
        else $error("frame B does not follow frame A");

    // With nothing waiting at the output, input is taken.
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");
endmodule

bind joystick_drive_mixer_framer jdm_checker u_jdm_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_ready         (i_in.ready),
    .o_out_valid        (o_out.valid),
    .o_out_ready        (o_out.ready),
    .o_out_motor_select (o_out.motor_select),
    .o_out_byte_index   (o_out.byte_index),
    .o_out_last_byte    (o_out.last_byte)
);
`default_nettype wire
